### hdl/eapg_pkg.sv
package eapg_pkg;

  localparam int unsigned MaxPoints   = 63;
  localparam int unsigned CordicSteps = 18;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned DivSteps    = 33;

  // Start value of the rotation, the inverse CORDIC gain in Q1.30.
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  localparam logic signed [63:0] HalfQ30 = 64'sd536870912;
  localparam logic signed [33:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [33:0] HalfTurn    = 34'sd2147483648;
  localparam logic [16:0] FullTurn = 17'h10000;

  // One point as the front end hands it to the rotation engine.
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius_x;
    logic [30:0]        radius_y;
    logic [31:0]        angle;
    logic [5:0]         index;
    logic               last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Arctangent of 2^-k in 2^-32 turn units, truncated.
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### hdl/eapg_front.sv
module eapg_front import eapg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [30:0]        radius_x_i,
  input  logic [30:0]        radius_y_i,
  input  logic [16:0]        angle_begin_i,
  input  logic [16:0]        angle_end_i,
  input  logic [5:0]         point_count_i,
  input  queue_stat_t        stat_i,
  output logic               push_o,
  output item_t              item_o
);

  typedef enum logic [2:0] {
    FeIdle = 3'b001,
    FeDiv  = 3'b010,
    FeEmit = 3'b100
  } fe_state_e;

  fe_state_e state_q, state_d;

  logic signed [31:0] cx_q, cy_q;
  logic [30:0] rx_q, ry_q;
  logic [16:0] start_q, sweep_q;
  logic [5:0]  n_q, d_q, idx_q, cnt_q, rem_q, accr_q;
  logic [32:0] quot_q, acc_q;

  logic [16:0] ab, ae, sweep_in, close_sum;
  logic [5:0]  n_in;
  logic [6:0]  rem_sh, rsum;
  logic        qbit;

  always_comb begin
    ab = (angle_begin_i > FullTurn) ? FullTurn : angle_begin_i;
    ae = (angle_end_i > FullTurn) ? FullTurn : angle_end_i;
    sweep_in = (ae >= ab) ? ae - ab : ae + FullTurn - ab;
    n_in = (point_count_i > 6'(MaxPoints)) ? 6'(MaxPoints) : point_count_i;
    rem_sh = {rem_q, quot_q[32]};
    qbit = rem_sh >= {1'b0, d_q};
    rsum = {1'b0, accr_q} + {1'b0, rem_q};
    close_sum = start_q + sweep_q;
  end

  assign in_ready_o = (state_q == FeIdle);
  assign push_o     = (state_q == FeEmit) && !stat_i.full;

  always_comb begin
    item_o.center_x = cx_q;
    item_o.center_y = cy_q;
    item_o.radius_x = rx_q;
    item_o.radius_y = ry_q;
    item_o.index    = idx_q;
    item_o.last     = (idx_q == n_q);
    if (idx_q == n_q) begin
      item_o.angle = {close_sum[15:0], 16'h0000};
    end else begin
      item_o.angle = {start_q[15:0], 16'h0000} + acc_q[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FeIdle: begin
        if (in_valid_i) begin
          state_d = (n_in >= 6'd2) ? FeDiv : FeEmit;
        end
      end
      FeDiv: begin
        if (cnt_q == 6'(DivSteps - 1)) state_d = FeEmit;
      end
      FeEmit: begin
        if (push_o && (idx_q == n_q)) state_d = FeIdle;
      end
      default: state_d = FeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FeIdle: begin
        if (in_valid_i) begin
          cx_q    <= center_x_i;
          cy_q    <= center_y_i;
          rx_q    <= radius_x_i;
          ry_q    <= radius_y_i;
          start_q <= ab;
          sweep_q <= sweep_in;
          n_q     <= n_in;
          d_q     <= n_in - 6'd1;
          idx_q   <= '0;
          cnt_q   <= '0;
          rem_q   <= '0;
          quot_q  <= {sweep_in, 16'h0000};
          acc_q   <= '0;
          accr_q  <= (n_in >= 6'd2) ? 6'((n_in - 6'd2) >> 1) : 6'd0;
        end
      end
      FeDiv: begin
        cnt_q  <= cnt_q + 6'd1;
        quot_q <= {quot_q[31:0], qbit};
        rem_q  <= qbit ? 6'(rem_sh - {1'b0, d_q}) : rem_sh[5:0];
      end
      FeEmit: begin
        if (push_o) begin
          idx_q <= idx_q + 6'd1;
          if (rsum >= {1'b0, d_q}) begin
            accr_q <= 6'(rsum - {1'b0, d_q});
            acc_q  <= acc_q + quot_q + 33'd1;
          end else begin
            accr_q <= rsum[5:0];
            acc_q  <= acc_q + quot_q;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### hdl/eapg_queue.sv
module eapg_queue import eapg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  item_t       item_i,
  input  logic        pop_i,
  output item_t       item_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hdl/eapg_back.sv
module eapg_back import eapg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  input  queue_stat_t        stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [5:0]         point_index_o,
  output logic               last_point_o
);

  typedef enum logic [4:0] {
    BeIdle = 5'b00001,
    BeRot  = 5'b00010,
    BeMulX = 5'b00100,
    BeMulY = 5'b01000,
    BeFin  = 5'b10000
  } be_state_e;

  be_state_e state_q, state_d;

  item_t              it_q;
  logic               flip_q;
  logic [4:0]         k_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] px_q;
  logic               out_valid_q;

  logic signed [33:0] z0, zf, xs, ys, at, cval, sval;
  logic               ff, out_free;
  logic signed [31:0] py_sat;

  function automatic logic signed [31:0] place(input logic signed [31:0] c,
                                               input logic signed [63:0] p);
    logic signed [33:0] off;
    logic signed [34:0] sum;
    off = 34'((p + HalfQ30) >>> 30);
    sum = 35'(c) + 35'(off);
    if (sum > 35'sd2147483647) return 32'sh7FFFFFFF;
    if (sum < -35'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  always_comb begin
    z0 = 34'(signed'(item_i.angle));
    zf = z0;
    ff = 1'b0;
    if (z0 > QuarterTurn) begin
      zf = z0 - HalfTurn;
      ff = 1'b1;
    end else if (z0 < -QuarterTurn) begin
      zf = z0 + HalfTurn;
      ff = 1'b1;
    end
    xs   = x_q >>> k_q;
    ys   = y_q >>> k_q;
    at   = 34'(signed'({1'b0, atan_turn(k_q)}));
    cval = flip_q ? -x_q : x_q;
    sval = flip_q ? -y_q : y_q;
    out_free = !out_valid_q || out_ready_i;
    py_sat = place(it_q.center_y, prod_q);
  end

  assign pop_o = (state_q == BeIdle) && !stat_i.empty;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BeIdle: if (!stat_i.empty) state_d = BeRot;
      BeRot:  if (k_q == 5'(CordicSteps - 1)) state_d = BeMulX;
      BeMulX: state_d = BeMulY;
      BeMulY: state_d = BeFin;
      BeFin:  if (out_free) state_d = BeIdle;
      default: state_d = BeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BeIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BeFin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BeIdle: begin
        if (!stat_i.empty) begin
          it_q   <= item_i;
          flip_q <= ff;
          z_q    <= zf;
          x_q    <= GainQ30;
          y_q    <= '0;
          k_q    <= '0;
        end
      end
      BeRot: begin
        k_q <= k_q + 5'd1;
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      BeMulX: begin
        prod_q <= $signed({1'b0, it_q.radius_x}) * $signed(cval[31:0]);
      end
      BeMulY: begin
        px_q   <= place(it_q.center_x, prod_q);
        prod_q <= $signed({1'b0, it_q.radius_y}) * $signed(sval[31:0]);
      end
      BeFin: begin
        if (out_free) begin
          point_x_o     <= px_q;
          point_y_o     <= py_sat;
          point_index_o <= it_q.index;
          last_point_o  <= it_q.last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/ellipse_arc_point_generator.sv
// Elliptical arc point generator.
// The input channel takes one arc request per transaction: centre, two
// semi-axes, start and end angle (65536 is a full turn) and a point count n.
// The output channel returns n evenly spaced points, counterclockwise from
// the start angle, then one closing point at the end angle flagged by
// last_point_o, each in a transaction of its own with its index.
// A new request is taken only once the front end has queued every point of
// the previous one; the front end runs a serial divider that splits the sweep
// into n-1 steps, then queues one point a cycle while the queue is not full.
// The back end works one point at a time: CORDIC rotation on a shift-and-add
// unit, then a single 32 by 32 multiplier for the x and y offsets in turn,
// then a load of the output register.
// Reset clears the state machines and queue pointers and leaves the output channel idle.
// When the receiver stalls, the output register holds its transaction, the
// back end waits with the next point finished, and the four-entry queue lets
// the front end keep working until it fills.
module ellipse_arc_point_generator import eapg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [30:0]        radius_x_i,
  input  logic [30:0]        radius_y_i,
  input  logic [16:0]        angle_begin_i,
  input  logic [16:0]        angle_end_i,
  input  logic [5:0]         point_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [5:0]         point_index_o,
  output logic               last_point_o
);

  item_t       push_item, pop_item;
  logic        push, pop;
  queue_stat_t stat;

  // Front end: latches the request and produces the angle of every point.
  eapg_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .center_x_i,
    .center_y_i,
    .radius_x_i,
    .radius_y_i,
    .angle_begin_i,
    .angle_end_i,
    .point_count_i,
    .stat_i (stat),
    .push_o (push),
    .item_o (push_item)
  );

  // Short queue that decouples angle generation from the rotation engine.
  eapg_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (stat)
  );

  // Back end: CORDIC rotation, scaling by the radii and saturation.
  eapg_back u_back (
    .clk_i,
    .rst_ni,
    .item_i (pop_item),
    .stat_i (stat),
    .pop_o  (pop),
    .out_valid_o,
    .out_ready_i,
    .point_x_o,
    .point_y_o,
    .point_index_o,
    .last_point_o
  );

endmodule
